>>> rtl/core/ps2mt_pkg.sv
package ps2mt_pkg;

    // Coordinate and register widths
    localparam int COORD_BITS = 12;
    localparam int POINTER_W  = 12;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int BYTE_W     = 8;
    localparam int DELTA_W    = BYTE_W + 1;

    // Wide enough for coordinate, size and a signed delta without overflow
    localparam int WIDE_W = ((COORD_BITS > CFG_W) ? COORD_BITS : CFG_W) + 2;

    localparam int COORD_MAX = (1 << COORD_BITS) - 1;

    // Reset values
    localparam logic [CFG_W-1:0]      RST_WIDTH  = CFG_W'(640);
    localparam logic [CFG_W-1:0]      RST_HEIGHT = CFG_W'(480);
    localparam logic [COORD_BITS-1:0] RST_POS_X  = COORD_BITS'(320);
    localparam logic [COORD_BITS-1:0] RST_POS_Y  = COORD_BITS'(240);

    // Status byte sign bits
    localparam int X_SIGN_POS = 4;
    localparam int Y_SIGN_POS = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TRACK  = 2'd2;

    // Packet phase codes
    localparam logic [1:0] PH_STATUS = 2'd0;
    localparam logic [1:0] PH_XMOVE  = 2'd1;
    localparam logic [1:0] PH_YMOVE  = 2'd2;

endpackage

>>> rtl/core/ps2mt_byte_if.sv
interface ps2mt_byte_if;
    import ps2mt_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

>>> rtl/core/ps2mt_ptr_if.sv
interface ps2mt_ptr_if;
    import ps2mt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [POINTER_W-1:0] pointer_x;
    logic [POINTER_W-1:0] pointer_y;
    logic                 moved;

    modport source (output valid, output pointer_x, output pointer_y, output moved,
                    input ready);
    modport sink (input valid, input pointer_x, input pointer_y, input moved,
                  output ready);
endinterface

>>> rtl/core/ps2mt_axis_update.sv
// One axis: apply a signed 9-bit delta and clamp to [0, size - 1]
module ps2mt_axis_update
    import ps2mt_pkg::*;
(
    input  logic [COORD_BITS-1:0]    i_pos,
    input  logic signed [DELTA_W-1:0] i_delta,
    input  logic                     i_sub,
    input  logic [CFG_W-1:0]         i_size,
    output logic [COORD_BITS-1:0]    o_pos
);

    logic signed [WIDE_W-1:0] w_pos;
    logic signed [WIDE_W-1:0] w_delta;
    logic signed [WIDE_W-1:0] w_sum;
    logic signed [WIDE_W-1:0] w_size_lim;
    logic signed [WIDE_W-1:0] w_limit;
    logic signed [WIDE_W-1:0] w_clamped;

    assign w_pos   = WIDE_W'($signed({1'b0, i_pos}));
    assign w_delta = WIDE_W'(i_delta);

    // Y moves the other way since screen rows grow downward
    assign w_sum = i_sub ? (w_pos - w_delta) : (w_pos + w_delta);

    // Size zero acts as size one; limit saturates at the coordinate range
    assign w_size_lim = (i_size == '0) ? '0
                      : (WIDE_W'($signed({1'b0, i_size})) - WIDE_W'(1));
    assign w_limit = (w_size_lim > WIDE_W'(COORD_MAX)) ? WIDE_W'(COORD_MAX) : w_size_lim;

    always_comb begin
        if (w_sum < 0) begin
            w_clamped = '0;
        end else if (w_sum > w_limit) begin
            w_clamped = w_limit;
        end else begin
            w_clamped = w_sum;
        end
    end

    assign o_pos = w_clamped[COORD_BITS-1:0];

endmodule

>>> rtl/core/ps2mt_pkg_unused_guard.sv
// Packet phase decoder: steers one received byte into the packet fields
module ps2mt_phase_dec
    import ps2mt_pkg::*;
(
    input  logic [1:0] i_phase,
    output logic       o_take_status,
    output logic       o_take_xmove,
    output logic       o_close,
    output logic [1:0] o_next_phase
);

    always_comb begin
        o_take_status = 1'b0;
        o_take_xmove  = 1'b0;
        o_close       = 1'b0;
        case (i_phase)
            PH_XMOVE: begin
                o_take_xmove = 1'b1;
                o_next_phase = PH_YMOVE;
            end
            PH_YMOVE: begin
                o_close      = 1'b1;
                o_next_phase = PH_STATUS;
            end
            // status phase, and the unused code, take a status byte
            default: begin
                o_take_status = 1'b1;
                o_next_phase  = PH_XMOVE;
            end
        endcase
    end

endmodule

>>> rtl/core/ps2_mouse_packet_tracker_unit.sv
// PS/2 mouse packet tracker. Raw mouse bytes enter on i_byte, one request per byte, and
// are grouped into three-byte packets (status, X move, Y move). Each completed packet
// yields one request on o_ptr with the clamped pointer position and a moved flag; the
// status and X bytes yield nothing. With tracking enabled X adds the 9-bit X delta and
// Y subtracts the 9-bit Y delta (sign bits 4 and 5 of the status byte), each clamped to
// 0..size-1; with tracking disabled the position holds and moved is 0. The block takes
// one byte per cycle while results are taken. A closing byte first sits in the input
// register; when it moves on, its result is loaded into the result register that drives
// o_ptr.valid. While a result waits in the result register no byte moves on: the input
// register takes one more byte, then i_byte.ready stays low until the result is taken.
// Configuration writes go through i_cfg_we/i_cfg_idx/i_cfg_data and are meant for idle
// periods only.
module ps2_mouse_packet_tracker_unit
    import ps2mt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    ps2mt_byte_if.sink           i_byte,
    ps2mt_ptr_if.source          o_ptr
);

    // Configuration registers
    logic [CFG_W-1:0] r_screen_width;
    logic [CFG_W-1:0] r_screen_height;
    logic             r_tracking_en;

    // Input register
    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;

    // Packet state
    logic [1:0]            r_phase;
    logic [BYTE_W-1:0]     r_status;
    logic [BYTE_W-1:0]     r_xmove;
    logic [COORD_BITS-1:0] r_pos_x;
    logic [COORD_BITS-1:0] r_pos_y;

    // Result register
    logic                 r_out_vld;
    logic [POINTER_W-1:0] r_out_x;
    logic [POINTER_W-1:0] r_out_y;
    logic                 r_out_moved;

    logic                     w_advance;
    logic                     w_take_status;
    logic                     w_take_xmove;
    logic                     w_close;
    logic [1:0]               n_phase;
    logic signed [DELTA_W-1:0] w_dx;
    logic signed [DELTA_W-1:0] w_dy;
    logic [COORD_BITS-1:0]    w_clamp_x;
    logic [COORD_BITS-1:0]    w_clamp_y;
    logic [COORD_BITS-1:0]    n_pos_x;
    logic [COORD_BITS-1:0]    n_pos_y;
    logic                     n_moved;

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= RST_WIDTH;
            r_screen_height <= RST_HEIGHT;
            r_tracking_en   <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDX_WIDTH:  r_screen_width  <= i_cfg_data;
                CFG_IDX_HEIGHT: r_screen_height <= i_cfg_data;
                CFG_IDX_TRACK:  r_tracking_en   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Byte in the input register moves on when the result slot is free or draining
    assign w_advance    = r_in_vld && (!r_out_vld || o_ptr.ready);
    assign i_byte.ready = !r_in_vld || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_byte.valid && i_byte.ready) begin
            r_in_vld <= 1'b1;
        end else if (w_advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.rx_byte;
        end
    end

    ps2mt_phase_dec u_phase (
        .i_phase       (r_phase),
        .o_take_status (w_take_status),
        .o_take_xmove  (w_take_xmove),
        .o_close       (w_close),
        .o_next_phase  (n_phase)
    );

    // Deltas: 9-bit two's complement, sign from the status byte
    assign w_dx = $signed({r_status[X_SIGN_POS], r_xmove});
    assign w_dy = $signed({r_status[Y_SIGN_POS], r_in_byte});

    ps2mt_axis_update u_axis_x (
        .i_pos   (r_pos_x),
        .i_delta (w_dx),
        .i_sub   (1'b0),
        .i_size  (r_screen_width),
        .o_pos   (w_clamp_x)
    );

    ps2mt_axis_update u_axis_y (
        .i_pos   (r_pos_y),
        .i_delta (w_dy),
        .i_sub   (1'b1),
        .i_size  (r_screen_height),
        .o_pos   (w_clamp_y)
    );

    assign n_pos_x = r_tracking_en ? w_clamp_x : r_pos_x;
    assign n_pos_y = r_tracking_en ? w_clamp_y : r_pos_y;
    assign n_moved = r_tracking_en && ((w_clamp_x != r_pos_x) || (w_clamp_y != r_pos_y));

    // Packet state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_STATUS;
            r_status <= '0;
            r_xmove  <= '0;
            r_pos_x  <= RST_POS_X;
            r_pos_y  <= RST_POS_Y;
        end else if (w_advance) begin
            r_phase <= n_phase;
            if (w_take_status) begin
                r_status <= r_in_byte;
            end
            if (w_take_xmove) begin
                r_xmove <= r_in_byte;
            end
            if (w_close) begin
                r_pos_x <= n_pos_x;
                r_pos_y <= n_pos_y;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_advance) begin
            r_out_vld <= w_close;
        end else if (o_ptr.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_close) begin
            r_out_x     <= POINTER_W'(n_pos_x);
            r_out_y     <= POINTER_W'(n_pos_y);
            r_out_moved <= n_moved;
        end
    end

    assign o_ptr.valid     = r_out_vld;
    assign o_ptr.pointer_x = r_out_x;
    assign o_ptr.pointer_y = r_out_y;
    assign o_ptr.moved     = r_out_moved;

    // A processed byte leaves a result exactly when it closed a packet
    a_result_on_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> (r_out_vld == $past(r_phase == PH_YMOVE)))
        else $error("result valid does not match packet close");

    // Moved flag agrees with the position change it reports
    a_moved_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_close) |=>
            (r_out_moved == ((r_pos_x != $past(r_pos_x)) || (r_pos_y != $past(r_pos_y)))))
        else $error("moved flag disagrees with position update");

    // Position only changes on a closing byte
    a_pos_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_advance && w_close) |=> ($stable(r_pos_x) && $stable(r_pos_y)))
        else $error("position changed outside a packet close");

endmodule

>>> verif/ps2_mouse_packet_tracker_unit_tb.sv
module ps2_mouse_packet_tracker_unit_tb
    import ps2mt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD       = 8;
    localparam int RESET_CYCLES     = 10;
    localparam int DRAIN_CYCLES     = 6;
    localparam int RANDOM_PHASES    = 8;
    localparam int BYTES_PER_PHASE  = 200;
    localparam int MAX_GAP          = 4;

    typedef struct packed {
        logic [POINTER_W-1:0] x;
        logic [POINTER_W-1:0] y;
        logic                 moved;
    } pointer_t;

    // One byte request; a pinned closing byte carries its hand-computed result
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              pinned;
        pointer_t          want;
    } mouse_byte_t;

    typedef enum logic {
        STEP_BYTE,
        STEP_REG
    } step_kind_e;

    typedef struct {
        step_kind_e           kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_val;
        mouse_byte_t          req;
    } plan_step_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    ps2mt_byte_if byte_bus ();
    ps2mt_ptr_if  ptr_bus ();

    ps2_mouse_packet_tracker_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_byte     (byte_bus),
        .o_ptr      (ptr_bus)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Tracker state mirrored on the testbench side
    logic [1:0]           trk_phase;
    logic [BYTE_W-1:0]    trk_status;
    logic [BYTE_W-1:0]    trk_xmove;
    logic [POINTER_W-1:0] trk_x;
    logic [POINTER_W-1:0] trk_y;
    logic [CFG_W-1:0]     trk_width;
    logic [CFG_W-1:0]     trk_height;
    logic                 trk_enable;

    mouse_byte_t sent_bytes_q[$];
    pointer_t    pointer_expect_q[$];
    plan_step_t  plan[$];
    int          mismatch_count = 0;
    int          bytes_sent = 0;
    bit          calm = 1'b0;
    int          drift_x = 0;
    int          drift_y = 0;

    // Clamp to 0..size-1; a zero size acts as one, the top saturates at the coordinate range
    function automatic int clamp_axis(int v, logic [CFG_W-1:0] size);
        int limit;
        limit = (size == '0) ? 0 : int'(size) - 1;
        if (limit > COORD_MAX) begin
            limit = COORD_MAX;
        end
        if (v < 0) begin
            return 0;
        end
        if (v > limit) begin
            return limit;
        end
        return v;
    endfunction

    // Advances the packet state by one byte; the Y byte closes a packet
    task automatic track_packet_byte(input logic [BYTE_W-1:0] b, output logic closes,
                                     output pointer_t res);
        int dx;
        int dy;
        closes = 1'b0;
        res = '0;
        case (trk_phase)
            PH_XMOVE: begin
                trk_xmove = b;
                trk_phase = PH_YMOVE;
            end
            PH_YMOVE: begin
                trk_phase = PH_STATUS;
                res.x = trk_x;
                res.y = trk_y;
                res.moved = 1'b0;
                if (trk_enable) begin
                    // 9-bit deltas, sign taken from the status byte
                    dx = trk_status[X_SIGN_POS] ? int'(trk_xmove) - (1 << BYTE_W)
                                                : int'(trk_xmove);
                    dy = trk_status[Y_SIGN_POS] ? int'(b) - (1 << BYTE_W) : int'(b);
                    res.x = POINTER_W'(clamp_axis(int'(trk_x) + dx, trk_width));
                    res.y = POINTER_W'(clamp_axis(int'(trk_y) - dy, trk_height));
                    res.moved = (res.x != trk_x) || (res.y != trk_y);
                    trk_x = res.x;
                    trk_y = res.y;
                end
                closes = 1'b1;
            end
            default: begin
                trk_status = b;
                trk_phase = PH_XMOVE;
            end
        endcase
    endtask

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Watch both channels; predict on every accepted byte, check every accepted result
    always @(posedge i_clk) begin : watch
        mouse_byte_t req;
        pointer_t    predicted;
        pointer_t    want;
        logic        closes;
        if (i_rst_n) begin
            if (byte_bus.valid && byte_bus.ready) begin
                req = sent_bytes_q.pop_front();
                track_packet_byte(req.value, closes, predicted);
                if (closes) begin
                    pointer_expect_q.push_back(req.pinned ? req.want : predicted);
                end
            end
            if (ptr_bus.valid && ptr_bus.ready) begin
                if (pointer_expect_q.size() == 0) begin
                    $display("%0t: unexpected pointer request x=%0d y=%0d moved=%0d", $time,
                             ptr_bus.pointer_x, ptr_bus.pointer_y, ptr_bus.moved);
                    mismatch_count++;
                end else begin
                    want = pointer_expect_q.pop_front();
                    check_field("pointer_x", want.x, ptr_bus.pointer_x);
                    check_field("pointer_y", want.y, ptr_bus.pointer_y);
                    check_field("moved", want.moved, ptr_bus.moved);
                end
            end
        end
    end

    // Result side: random stall before taking each request
    initial begin : pointer_sink
        int stall;
        ptr_bus.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                ptr_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            ptr_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!ptr_bus.valid);
        end
    end

    task automatic send_byte(input mouse_byte_t req);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            byte_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sent_bytes_q.push_back(req);
        byte_bus.valid   <= 1'b1;
        byte_bus.rx_byte <= req.value;
        bytes_sent++;
        do @(posedge i_clk); while (!byte_bus.ready);
    endtask

    // Stop sending and wait out every outstanding pointer request
    task automatic drain_results();
        byte_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pointer_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_IDX_WIDTH:  trk_width = val;
            CFG_IDX_HEIGHT: trk_height = val;
            CFG_IDX_TRACK:  trk_enable = val[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic plan_byte(input logic [BYTE_W-1:0] v);
        plan_step_t s;
        s.kind = STEP_BYTE;
        s.reg_idx = '0;
        s.reg_val = '0;
        s.req.value = v;
        s.req.pinned = 1'b0;
        s.req.want = '0;
        plan.push_back(s);
    endtask

    task automatic plan_close(input logic [BYTE_W-1:0] v, input int x, input int y,
                              input logic m);
        plan_step_t s;
        s.kind = STEP_BYTE;
        s.reg_idx = '0;
        s.reg_val = '0;
        s.req.value = v;
        s.req.pinned = 1'b1;
        s.req.want.x = POINTER_W'(x);
        s.req.want.y = POINTER_W'(y);
        s.req.want.moved = m;
        plan.push_back(s);
    endtask

    task automatic plan_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        plan_step_t s;
        s.kind = STEP_REG;
        s.reg_idx = idx;
        s.reg_val = CFG_W'(val);
        s.req = '0;
        plan.push_back(s);
    endtask

    // Screen size pick, weighted toward the edges
    function automatic logic [CFG_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return CFG_W'(0);
            1:       return CFG_W'(1);
            2:       return CFG_W'(2);
            3:       return CFG_W'($urandom_range(3, 300));
            4:       return CFG_W'(640);
            5:       return CFG_W'(COORD_MAX);
            6:       return CFG_W'(COORD_MAX + 1);
            7:       return CFG_W'(COORD_MAX + 2);
            8:       return '1;
            default: return CFG_W'($urandom);
        endcase
    endfunction

    // Random byte; status bytes lean toward the phase's drift so clamps get hit
    function automatic logic [BYTE_W-1:0] random_mouse_byte(int slot);
        logic [BYTE_W-1:0] v;
        v = BYTE_W'($urandom);
        if (slot == 0) begin
            if (drift_x != 0 && $urandom_range(0, 7) != 0) begin
                v[X_SIGN_POS] = (drift_x < 0);
            end
            if (drift_y != 0 && $urandom_range(0, 7) != 0) begin
                v[Y_SIGN_POS] = (drift_y < 0);
            end
        end else if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
                0:       v = 8'h00;
                1:       v = 8'hFF;
                2:       v = 8'h80;
                default: v = 8'h7F;
            endcase
        end
        return v;
    endfunction

    initial begin : stimulus
        mouse_byte_t req;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= '0;
        i_cfg_data       <= '0;
        byte_bus.valid   <= 1'b0;
        byte_bus.rx_byte <= '0;
        trk_phase  = PH_STATUS;
        trk_status = '0;
        trk_xmove  = '0;
        trk_x      = RST_POS_X;
        trk_y      = RST_POS_Y;
        trk_width  = RST_WIDTH;
        trk_height = RST_HEIGHT;
        trk_enable = 1'b1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed packets: status, X move, Y move
        plan_byte(8'h00); plan_byte(8'h00); plan_close(8'h00, 320, 240, 1'b0);
        plan_byte(8'h00); plan_byte(8'hFF); plan_close(8'h00, 575, 240, 1'b1);
        // Y sign set, full negative delta pushes Y past the bottom edge
        plan_byte(8'h20); plan_byte(8'h00); plan_close(8'h00, 575, 479, 1'b1);
        plan_byte(8'h10); plan_byte(8'h00); plan_close(8'hFF, 319, 224, 1'b1);
        // Tracking off while the width shrinks: position held past the new edge
        plan_reg(CFG_IDX_TRACK, 0);
        plan_reg(CFG_IDX_WIDTH, 100);
        plan_byte(8'h00); plan_byte(8'hFF); plan_close(8'h00, 319, 224, 1'b0);
        // Back on: the held X snaps to the shrunk edge
        plan_reg(CFG_IDX_TRACK, 1);
        plan_byte(8'h00); plan_byte(8'h00); plan_close(8'h00, 99, 224, 1'b1);
        // Button and overflow bits set in the status byte are ignored
        plan_byte(8'hDF); plan_byte(8'h80); plan_close(8'h7F, 0, 97, 1'b1);
        // Zero size behaves as a size of one
        plan_reg(CFG_IDX_WIDTH, 0);
        plan_reg(CFG_IDX_HEIGHT, 0);
        plan_byte(8'h00); plan_byte(8'h7F); plan_close(8'h80, 0, 0, 1'b1);
        // Sizes beyond the coordinate range
        plan_reg(CFG_IDX_WIDTH, 8191);
        plan_reg(CFG_IDX_HEIGHT, 4096);
        plan_byte(8'h00); plan_byte(8'hFF); plan_close(8'h80, 255, 0, 1'b1);

        foreach (plan[i]) begin
            if (plan[i].kind == STEP_REG) begin
                drain_results();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                send_byte(plan[i].req);
            end
        end

        // Random phases, each with its own screen setup, drift and idling mode
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_results();
            write_reg(CFG_IDX_WIDTH, pick_size());
            write_reg(CFG_IDX_HEIGHT, pick_size());
            write_reg(CFG_IDX_TRACK, CFG_W'($urandom_range(0, 4) != 0));
            drift_x = int'($urandom_range(0, 2)) - 1;
            drift_y = int'($urandom_range(0, 2)) - 1;
            calm = (ph % 4 == 3);
            for (int n = 0; n < BYTES_PER_PHASE; n++) begin
                req = '0;
                req.value = random_mouse_byte(bytes_sent % 3);
                send_byte(req);
            end
        end
        calm = 1'b0;

        drain_results();
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("%0t: timeout, %0d pointer requests outstanding", $time,
                 pointer_expect_q.size());
        $display("status: fail");
        $finish;
    end

endmodule
